[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// constants, command codes and job type of the prefix-code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int SYM_W   = 8;
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int ADDR_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FLUSH  = 1'b1
    } job_op_t;

    typedef struct packed {
        job_op_t           op;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } job_t;

endpackage

[sv/hcbp_if.sv]
// ----------------------------------------------------------------------------
// hcbp_if
// valid/ready channels for input items and packed output bytes
// ----------------------------------------------------------------------------
interface hcbp_item_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;

    modport source (output valid, cmd, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, cmd, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_result_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

[sv/hcbp_ram.sv]
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/hcbp_front.sv]
// ----------------------------------------------------------------------------
// hcbp_front
// accepts items, writes and reads the code table, issues encode/flush jobs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_front (
    input  logic          clk,
    input  logic          rst_n,
    hcbp_item_if.sink     item,
    output logic          job_valid,
    input  logic          job_ready,
    output hcbp_pkg::job_t job
);
    import hcbp_pkg::*;

    logic               accept;
    logic               sym_ok;
    logic [LEN_W-1:0]   len_sat;
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               issue;
    job_op_t            issue_op;

    logic    s1_valid_reg, s1_valid_next;
    job_op_t s1_op_reg, s1_op_next;

    assign item.ready = !s1_valid_reg || job_ready;
    assign accept     = item.valid && item.ready;
    assign sym_ok     = {1'b0, item.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
    assign len_sat    = (item.code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : item.code_len;

    always_comb
    begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        issue    = 1'b0;
        issue_op = OP_ENCODE;
        unique case (item.cmd)
            CMD_LOAD:
            begin
                ram_we = accept && sym_ok;
            end
            CMD_ENCODE:
            begin
                ram_re   = accept && sym_ok;
                issue    = accept && sym_ok;
                issue_op = OP_ENCODE;
            end
            CMD_FLUSH:
            begin
                issue    = accept;
                issue_op = OP_FLUSH;
            end
            default:
            begin
            end
        endcase
    end

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_code_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.symbol[ADDR_W-1:0]),
        .wdata ({len_sat, item.code_bits}),
        .re    (ram_re),
        .raddr (item.symbol[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !job_ready;
        s1_op_next    = s1_op_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
            s1_op_next    = issue_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_ENCODE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_op_reg    <= s1_op_next;
        end
    end

    assign job_valid = s1_valid_reg;

    always_comb
    begin
        job.op   = s1_op_reg;
        job.code = ram_rdata[CODE_W-1:0];
        job.len  = ram_rdata[ENTRY_W-1:CODE_W];
        if (s1_op_reg == OP_FLUSH)
        begin
            job.code = '0;
            job.len  = '0;
        end
    end

    `ASSERT_CLK(a_front_hold, clk, rst_n, (s1_valid_reg && !job_ready) |=> (s1_valid_reg && $stable(s1_op_reg)), "front job dropped while queue full")

endmodule

[sv/hcbp_queue.sv]
// ----------------------------------------------------------------------------
// hcbp_queue
// short job fifo between the table front end and the bit packer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  hcbp_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hcbp_pkg::job_t pop_job
);
    import hcbp_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_ALWAYS(a_queue_bound, clk, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

[sv/hcbp_back.sv]
// ----------------------------------------------------------------------------
// hcbp_back
// shifts code bits into the partial byte and emits at most one byte per cycle while the result channel is not stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  hcbp_pkg::job_t job,
    hcbp_result_if.source  result
);
    import hcbp_pkg::*;

    logic                busy_reg, busy_next;
    logic [CODE_W-1:0]   sr_reg, sr_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [BYTE_W-1:0]   pbyte_reg, pbyte_next;
    logic [2:0]          pcnt_reg, pcnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    logic                step_ok;
    logic                take;
    logic [3:0]          room;
    logic [3:0]          k;
    logic [3:0]          total;
    logic [BYTE_W-1:0]   newbits;
    logic [2*BYTE_W-1:0] acc_wide;
    logic [BYTE_W-1:0]   acc;
    logic [LEN_W-1:0]    rem_left;
    logic [2*BYTE_W-1:0] flush_wide;

    assign step_ok   = !out_valid_reg || result.ready;
    assign job_ready = !busy_reg && step_ok;
    assign take      = job_valid && job_ready;

    // bits taken this cycle: up to the free room of the partial byte
    assign room       = 4'd8 - {1'b0, pcnt_reg};
    assign k          = (rem_reg < {2'b00, room}) ? rem_reg[3:0] : room;
    assign total      = {1'b0, pcnt_reg} + k;
    assign newbits    = sr_reg[CODE_W-1 -: BYTE_W] >> (4'd8 - k);
    assign acc_wide   = {{BYTE_W{1'b0}}, pbyte_reg} << k;
    assign acc        = acc_wide[BYTE_W-1:0] | newbits;
    assign rem_left   = rem_reg - {2'b00, k};
    assign flush_wide = {{BYTE_W{1'b0}}, pbyte_reg} << (4'd8 - {1'b0, pcnt_reg});

    always_comb
    begin
        busy_next      = busy_reg;
        sr_next        = sr_reg;
        rem_next       = rem_reg;
        pbyte_next     = pbyte_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (busy_reg && step_ok)
        begin
            sr_next   = sr_reg << k;
            rem_next  = rem_left;
            busy_next = rem_left != '0;
            if (total[3])
            begin
                out_valid_next = 1'b1;
                out_byte_next  = acc;
                out_last_next  = rem_left < LEN_W'(BYTE_W);
                pbyte_next     = '0;
                pcnt_next      = '0;
            end
            else
            begin
                pbyte_next = acc;
                pcnt_next  = total[2:0];
            end
        end
        else if (take)
        begin
            unique case (job.op)
                OP_ENCODE:
                begin
                    sr_next   = job.code << (LEN_W'(CODE_W) - job.len);
                    rem_next  = job.len;
                    busy_next = job.len != '0;
                end
                OP_FLUSH:
                begin
                    if (pcnt_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = flush_wide[BYTE_W-1:0];
                        out_last_next  = 1'b1;
                    end
                    pbyte_next = '0;
                    pcnt_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            pbyte_reg     <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rem_reg       <= rem_next;
            pbyte_reg     <= pbyte_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.last_of_run = out_last_reg;

    `ASSERT_CLK(a_back_busy_rem, clk, rst_n, busy_reg |-> (rem_reg != '0), "packer busy with no bits left")
    `ASSERT_CLK(a_back_stall, clk, rst_n, (out_valid_reg && !result.ready) |=> ($stable(pcnt_reg) && $stable(rem_reg) && $stable(busy_reg)), "packer moved while output stalled")

endmodule

[sv/huffman_code_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// prefix-code table with msb-first bit packing into bytes
// ----------------------------------------------------------------------------
// channel  dir  fields
// item     in   cmd[1:0], symbol[7:0], code_bits[31:0], code_len[5:0]
// result   out  out_byte[7:0], last_of_run
//
// load writes the table; encode reads it (registered read), then the packer
// takes the job and moves at most one byte's worth of bits per cycle unless
// the result word stalls; flush pads and emits any partial byte; a two-entry
// job queue decouples front and packer; no clearing pass after reset
// reset is asynchronous, active low; a stalled result word holds the packer
// a full queue and a held front job together hold item ready low
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
    input  logic          clk,
    input  logic          rst_n,
    hcbp_item_if.sink     item,
    hcbp_result_if.source result
);
    import hcbp_pkg::*;

    logic f_valid;
    logic f_ready;
    job_t f_job;
    logic b_valid;
    logic b_ready;
    job_t b_job;

    hcbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .result    (result)
    );

endmodule

[test/huffman_code_bit_packer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_test
// drives load, encode, flush and unused commands through the item channel,
// first from a short table of edge cases and then at random over a growing
// set of loaded codes. Table rows marked typed are checked against the bytes
// they list, all other bytes against a bit-serial model of the code table and
// the partial-byte accumulator. Both channels idle at random, and the result
// side holds off once long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_test;
    import hcbp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_WORDS    = 420;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } item_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } byte_word_t;

    typedef struct packed {
        item_word_t  w;
        bit          typed;
        logic [2:0]  n_typed;
        logic [39:0] typed_bytes;
    } dir_row_t;

    logic clk;
    logic rst_n;

    hcbp_item_if   item_ch ();
    hcbp_result_if result_ch ();

    huffman_code_bit_packer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // model state
    logic [CODE_W-1:0] code_tab_bits [NUM_SYMBOLS];
    int                code_tab_len  [NUM_SYMBOLS];
    logic [7:0]        pend_byte;
    int                pend_cnt;
    byte_word_t        packed_now [$];

    byte_word_t bytes_due [$];
    bit         entry_loaded [NUM_SYMBOLS];
    int         loaded_syms [$];
    dir_row_t   dir_rows [$];
    int         fail_count;
    int         idle_cycles;
    bit         send_burst;
    bit         hold_off_armed;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void pack_code_word(input item_word_t w);
        int len;
        packed_now.delete();
        case (w.cmd)
            CMD_LOAD:
            begin
                if (w.symbol < NUM_SYMBOLS)
                begin
                    len = w.code_len;
                    if (len > LEN_CAP)
                        len = LEN_CAP;
                    code_tab_bits[w.symbol] = w.code_bits;
                    code_tab_len[w.symbol]  = len;
                end
            end
            CMD_ENCODE:
            begin
                if (w.symbol < NUM_SYMBOLS)
                begin
                    for (int i = code_tab_len[w.symbol]; i > 0; i--)
                    begin
                        pend_byte = {pend_byte[6:0], code_tab_bits[w.symbol][i-1]};
                        pend_cnt++;
                        if (pend_cnt == 8)
                        begin
                            packed_now.push_back('{pend_byte, 1'b0});
                            pend_byte = '0;
                            pend_cnt  = 0;
                        end
                    end
                    if (packed_now.size() > 0)
                        packed_now[packed_now.size()-1].last_of_run = 1'b1;
                end
            end
            CMD_FLUSH:
            begin
                if (pend_cnt > 0)
                    packed_now.push_back('{8'(pend_byte << (8 - pend_cnt)), 1'b1});
                pend_byte = '0;
                pend_cnt  = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_burst || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t row(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                     input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                                     input bit typed, input int n, input logic [39:0] bytes);
        dir_row_t r;
        r.w           = '{cmd, sym, bits, len};
        r.typed       = typed;
        r.n_typed     = 3'(n);
        r.typed_bytes = bytes;
        return r;
    endfunction

    task automatic send_word(input item_word_t w, input bit typed, input int n_typed,
                             input logic [39:0] typed_bytes);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= w.cmd;
        item_ch.symbol    <= w.symbol;
        item_ch.code_bits <= w.code_bits;
        item_ch.code_len  <= w.code_len;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        pack_code_word(w);
        if (w.cmd == CMD_LOAD && !entry_loaded[w.symbol])
        begin
            entry_loaded[w.symbol] = 1'b1;
            loaded_syms.push_back(w.symbol);
        end
        if (typed)
        begin
            for (int k = 0; k < n_typed; k++)
                bytes_due.push_back('{typed_bytes[39-8*k -: 8], k == n_typed - 1});
        end
        else
        begin
            foreach (packed_now[k])
                bytes_due.push_back(packed_now[k]);
        end
    endtask

    function automatic item_word_t random_word();
        item_word_t w;
        int r;
        int s;
        w.symbol    = 8'($urandom_range(0, 255));
        w.code_bits = $urandom;
        w.code_len  = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            w.cmd = CMD_LOAD;
            s = $urandom_range(0, 99);
            if (s < 10)
                w.code_len = 6'd0;
            else if (s < 60)
                w.code_len = 6'($urandom_range(1, 8));
            else if (s < 85)
                w.code_len = 6'($urandom_range(9, 32));
            else
                w.code_len = 6'($urandom_range(33, 63));
        end
        else if (r < 85)
        begin
            w.cmd    = CMD_ENCODE;
            w.symbol = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        end
        else if (r < 95)
            w.cmd = CMD_FLUSH;
        else
            w.cmd = CMD_UNUSED;
        return w;
    endfunction

    // result side
    initial
    begin
        int run;
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                run = $urandom_range(100, 300);
            else
                run = $urandom_range(1, 20);
            repeat (run) @(posedge clk);
            send_burst = send_burst;
            gap = $urandom_range(0, 99) < 50 ? 0 : pick_gap();
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        byte_word_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual out_byte %02h last %0b",
                         $time, result_ch.out_byte, result_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                e = bytes_due.pop_front();
                if (result_ch.out_byte !== e.out_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, e.out_byte, result_ch.out_byte);
                    fail_count++;
                end
                if (result_ch.last_of_run !== e.last_of_run)
                begin
                    $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                             $time, e.last_of_run, result_ch.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("huffman_code_bit_packer verification failed");
            $finish;
        end
    end

    initial
    begin
        item_word_t w;
        dir_row_t   d;
        fail_count     = 0;
        idle_cycles    = 0;
        send_burst     = 1'b0;
        hold_off_armed = 1'b0;
        pend_byte      = '0;
        pend_cnt       = 0;
        foreach (code_tab_bits[i])
        begin
            code_tab_bits[i] = '0;
            code_tab_len[i]  = 0;
            entry_loaded[i]  = 1'b0;
        end
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.cmd       <= CMD_LOAD;
        item_ch.symbol    <= '0;
        item_ch.code_bits <= '0;
        item_ch.code_len  <= '0;

        dir_rows.push_back(row(CMD_FLUSH,  8'h00, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_UNUSED, 8'hFF, 32'hFFFFFFFF, 6'd63, 1, 0, 40'h0));
        dir_rows.push_back(row(CMD_LOAD,   8'h00, 32'hFFFFFFFF, 6'd32, 1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h00, 32'h0,        6'd0,  1, 4, 40'hFFFFFFFF00));
        dir_rows.push_back(row(CMD_LOAD,   8'hFF, 32'h0,        6'd63, 1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'hFF, 32'hFFFFFFFF, 6'd63, 1, 4, 40'h0));
        dir_rows.push_back(row(CMD_LOAD,   8'h01, 32'h1,        6'd1,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h01, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h00, 32'h0,        6'd0,  1, 4, 40'hFFFFFFFF00));
        dir_rows.push_back(row(CMD_FLUSH,  8'h00, 32'h0,        6'd0,  1, 1, 40'h8000000000));
        dir_rows.push_back(row(CMD_LOAD,   8'h02, 32'hAAAAAAAA, 6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h02, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_FLUSH,  8'h00, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_LOAD,   8'h03, 32'hFFFFFFF5, 6'd3,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h03, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_FLUSH,  8'hFF, 32'hFFFFFFFF, 6'd63, 1, 1, 40'hA000000000));
        dir_rows.push_back(row(CMD_LOAD,   8'h04, 32'h0000007F, 6'd7,  0, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h04, 32'h0,        6'd0,  0, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h00, 32'h0,        6'd0,  0, 0, 40'h0));
        dir_rows.push_back(row(CMD_LOAD,   8'h00, 32'h12345678, 6'd40, 0, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h00, 32'h0,        6'd0,  0, 0, 40'h0));
        dir_rows.push_back(row(CMD_UNUSED, 8'h00, 32'h0,        6'd0,  1, 0, 40'h0));
        dir_rows.push_back(row(CMD_FLUSH,  8'h00, 32'h0,        6'd0,  0, 0, 40'h0));
        dir_rows.push_back(row(CMD_LOAD,   8'h80, 32'h80000000, 6'd33, 0, 0, 40'h0));
        dir_rows.push_back(row(CMD_ENCODE, 8'h80, 32'h0,        6'd0,  0, 0, 40'h0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            send_word(d.w, d.typed, d.n_typed, d.typed_bytes);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 30 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if (i == 100)
            begin
                send_burst     = 1'b1;
                hold_off_armed = 1'b1;
            end
            w = random_word();
            send_word(w, 1'b0, 0, 40'h0);
        end
        item_ch.valid <= 1'b0;

        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && bytes_due.size() == 0)
            $display("huffman_code_bit_packer verification clean");
        else
            $display("huffman_code_bit_packer verification failed");
        $finish;
    end

endmodule
